// ----- rtl/mrc_pkg.sv -----
// Package for the Modbus RTU response checker: types, codes, constants
// and the byte-wide CRC-16 step. No dependencies.

package mrc_pkg;

    localparam int unsigned MaxFrameBytesDef = 255;

    localparam int unsigned PosW   = 9;
    localparam logic [PosW-1:0] PosMax = 9'd511;

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    localparam logic [7:0] FuncReadHold   = 8'h03;
    localparam logic [7:0] FuncWriteMulti = 8'h10;
    localparam logic [7:0] ExceptionBit   = 8'h80;

    localparam logic [7:0] SlaveRst    = 8'd1;
    localparam logic [7:0] FunctionRst = 8'd3;
    localparam logic [6:0] MaxWordsRst = 7'd64;

    typedef enum logic [1:0] {
        CFG_SLAVE     = 2'd0,
        CFG_FUNCTION  = 2'd1,
        CFG_MAX_WORDS = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_CRC       = 3'd2,
        ST_SLAVE     = 3'd3,
        ST_EXCEPTION = 3'd4,
        ST_FUNCTION  = 3'd5,
        ST_LENGTH    = 3'd6,
        ST_OVERLONG  = 3'd7
    } t_status;

    typedef struct packed {
        logic [7:0] slave;
        logic [7:0] func;
        logic [6:0] max_words;
    } t_cfg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_beat;

    typedef struct packed {
        logic        kind;
        logic [6:0]  word_index;
        logic [15:0] word_value;
        logic [2:0]  status;
    } t_result;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/mrc_rx_if.sv -----
// Input channel of the response checker: one received byte per beat.
// No dependencies.

interface mrc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source(output valid, output rx_byte, output frame_end, input ready);
    modport sink(input valid, input rx_byte, input frame_end, output ready);
endinterface

// ----- rtl/mrc_res_if.sv -----
// Result channel of the response checker: a data word or a frame status per beat.
// No dependencies.

interface mrc_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [6:0]  word_index;
    logic [15:0] word_value;
    logic [2:0]  status;

    modport source(output valid, output kind, output word_index, output word_value,
                   output status, input ready);
    modport sink(input valid, input kind, input word_index, input word_value,
                 input status, output ready);
endinterface

// ----- rtl/mrc_frame_core.sv -----
// Frame state, CRC tracking and result register of the response checker.
// Depends on mrc_pkg.

module mrc_frame_core
    import mrc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDef
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_item_valid,
    input  t_in_beat i_item,
    output logic     o_item_ready,
    output logic     o_res_valid,
    output t_result  o_res,
    input  logic     i_res_ready
);

    localparam logic [PosW-1:0] MaxLen = PosW'(MAX_FRAME_BYTES);

    logic [PosW-1:0] r_pos, n_pos;
    logic [15:0]     r_crc_now, n_crc_now;
    logic [15:0]     r_crc_one, n_crc_one;
    logic [7:0]      r_slave, n_slave;
    logic [7:0]      r_func, n_func;
    logic [7:0]      r_count, n_count;
    logic [7:0]      r_high, n_high;
    logic [7:0]      r_tail_lo, n_tail_lo;
    logic            r_res_valid, n_res_valid;
    t_result         r_res, n_res;

    logic            take;
    logic [7:0]      b;
    logic [PosW-1:0] pos_inc;
    logic [PosW-1:0] pos_m4;
    logic [7:0]      widx;
    logic            word_out;
    logic [15:0]     rx_crc;
    t_status         st;

    assign o_item_ready = !r_res_valid || i_res_ready;
    assign take         = i_item_valid && o_item_ready;
    assign b            = i_item.rx_byte;
    assign pos_inc      = (r_pos < PosMax) ? r_pos + 9'd1 : r_pos;
    assign pos_m4       = r_pos - 9'd4;
    assign widx         = pos_m4[8:1];
    assign rx_crc       = {b, r_tail_lo};

    always_comb begin
        word_out = 1'b0;
        if (r_pos > 9'd2 && !r_pos[0]) begin
            word_out = (i_cfg.func == FuncReadHold) && (widx < {1'b0, r_count[7:1]})
                       && (widx < {1'b0, i_cfg.max_words});
        end
    end

    always_comb begin
        if (pos_inc > MaxLen) begin
            st = ST_OVERLONG;
        end else if (pos_inc < 9'd4) begin
            st = ST_SHORT;
        end else if (rx_crc != r_crc_one) begin
            st = ST_CRC;
        end else if (r_slave != i_cfg.slave) begin
            st = ST_SLAVE;
        end else if ((r_func & ExceptionBit) != 8'h00) begin
            st = ST_EXCEPTION;
        end else if (r_func != i_cfg.func) begin
            st = ST_FUNCTION;
        end else if (i_cfg.func == FuncReadHold && ({1'b0, r_count} + 9'd5) != pos_inc) begin
            st = ST_LENGTH;
        end else if (i_cfg.func == FuncWriteMulti && pos_inc != 9'd8) begin
            st = ST_LENGTH;
        end else begin
            st = ST_OK;
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_crc_now = r_crc_now;
        n_crc_one = r_crc_one;
        n_slave   = r_slave;
        n_func    = r_func;
        n_count   = r_count;
        n_high    = r_high;
        n_tail_lo = r_tail_lo;
        if (take) begin
            if (i_item.frame_end) begin
                n_pos     = '0;
                n_crc_now = CrcInit;
                n_crc_one = CrcInit;
                n_slave   = '0;
                n_func    = '0;
                n_count   = '0;
                n_high    = '0;
                n_tail_lo = '0;
            end else begin
                n_pos     = pos_inc;
                n_crc_one = r_crc_now;
                n_crc_now = crc16_byte(r_crc_now, b);
                n_tail_lo = b;
                if (r_pos == 9'd0) begin
                    n_slave = b;
                end else if (r_pos == 9'd1) begin
                    n_func = b;
                end else if (r_pos == 9'd2) begin
                    n_count = b;
                end else if (r_pos[0]) begin
                    n_high = b;
                end
            end
        end
    end

    always_comb begin
        n_res_valid = r_res_valid;
        n_res       = r_res;
        if (o_item_ready) begin
            n_res_valid = take && (i_item.frame_end || word_out);
            if (i_item.frame_end) begin
                n_res.kind       = 1'b1;
                n_res.word_index = '0;
                n_res.word_value = '0;
                n_res.status     = st;
            end else begin
                n_res.kind       = 1'b0;
                n_res.word_index = widx[6:0];
                n_res.word_value = {r_high, b};
                n_res.status     = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_crc_now   <= CrcInit;
            r_crc_one   <= CrcInit;
            r_slave     <= '0;
            r_func      <= '0;
            r_count     <= '0;
            r_high      <= '0;
            r_tail_lo   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc_now   <= n_crc_now;
            r_crc_one   <= n_crc_one;
            r_slave     <= n_slave;
            r_func      <= n_func;
            r_count     <= n_count;
            r_high      <= n_high;
            r_tail_lo   <= n_tail_lo;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ----- rtl/modbus_rtu_response_checker.sv -----
// Modbus RTU response checker: input register, configuration registers and frame core.
// Depends on mrc_pkg, mrc_rx_if, mrc_res_if and mrc_frame_core.
// Each result beat is registered in the core after its byte passes the input register.
// Throughput: one byte per cycle unless results stall; CRC and checks are combinational.
// Reset: synchronous, active low; frame state, valid flags and config registers are reset.

module modbus_rtu_response_checker
    import mrc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    mrc_rx_if.sink     i_rx,
    mrc_res_if.source  o_res
);

    t_cfg     r_cfg;
    logic     r_in_valid;
    t_in_beat r_in_beat;
    logic     core_ready;
    logic     res_valid;
    t_result  res;

    assign i_rx.ready = !r_in_valid || core_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave     <= SlaveRst;
            r_cfg.func      <= FunctionRst;
            r_cfg.max_words <= MaxWordsRst;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLAVE:     r_cfg.slave     <= i_cfg_data;
                CFG_FUNCTION:  r_cfg.func      <= i_cfg_data;
                CFG_MAX_WORDS: r_cfg.max_words <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_beat.rx_byte   <= i_rx.rx_byte;
            r_in_beat.frame_end <= i_rx.frame_end;
        end
    end

    mrc_frame_core #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (r_in_valid),
        .i_item       (r_in_beat),
        .o_item_ready (core_ready),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (o_res.ready)
    );

    assign o_res.valid      = res_valid;
    assign o_res.kind       = res.kind;
    assign o_res.word_index = res.word_index;
    assign o_res.word_value = res.word_value;
    assign o_res.status     = res.status;

endmodule

// ----- rtl/mrc_checker.sv -----
// Port-level assertions for the Modbus RTU response checker, bound to its top level.
// Depends on mrc_pkg and modbus_rtu_response_checker.

module mrc_checker
    import mrc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_kind,
    input logic [6:0]  i_word_index,
    input logic [15:0] i_word_value,
    input logic [2:0]  i_status
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat valid right after reset");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind) |-> (i_word_index == 7'd0 && i_word_value == 16'd0))
        else $error("status beat carries word fields");

    a_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_kind) |-> (i_status == ST_OK))
        else $error("word beat carries a status code");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_kind) && $stable(i_word_index)
             && $stable(i_word_value) && $stable(i_status)))
        else $error("stalled result beat changed");

endmodule

bind modbus_rtu_response_checker mrc_checker u_mrc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_kind       (o_res.kind),
    .i_word_index (o_res.word_index),
    .i_word_value (o_res.word_value),
    .i_status     (o_res.status)
);
